// ===== src/psg_pkg.sv =====
// Shared types, codes and amplitude table for the PSG tone/noise/envelope unit.
package psg_pkg;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_SELECT = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Register file addresses
  localparam logic [3:0] ADDR_TONE_A_LO = 4'd0;
  localparam logic [3:0] ADDR_TONE_A_HI = 4'd1;
  localparam logic [3:0] ADDR_TONE_B_HI = 4'd3;
  localparam logic [3:0] ADDR_TONE_C_HI = 4'd5;
  localparam logic [3:0] ADDR_NOISE     = 4'd6;
  localparam logic [3:0] ADDR_MIXER     = 4'd7;
  localparam logic [3:0] ADDR_AMP_A     = 4'd8;
  localparam logic [3:0] ADDR_AMP_B     = 4'd9;
  localparam logic [3:0] ADDR_AMP_C     = 4'd10;
  localparam logic [3:0] ADDR_ENV_LO    = 4'd11;
  localparam logic [3:0] ADDR_ENV_HI    = 4'd12;
  localparam logic [3:0] ADDR_SHAPE     = 4'd13;

  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned NUM_CHAN = 3;
  localparam logic [7:0]  MIXER_RESET = 8'h3F;
  localparam int unsigned MIX_W = 17;
  localparam logic [3:0]  VOL_MAX = 4'hF;
  localparam logic [3:0]  VOL_MIN = 4'h0;

  // Per-channel inputs to the output gating stage
  typedef struct packed {
    logic       tone_off;
    logic       noise_off;
    logic       env_mode;
    logic [3:0] fixed_vol;
    logic [3:0] env_vol;
    logic       tone_lvl;
    logic       noise_lvl;
  } psg_chan_t;

  // Q1.15 amplitude for each 4-bit volume code
  function automatic logic [MIX_W-1:0] amp_q15(input logic [3:0] code);
    logic [MIX_W-1:0] a;
    case (code)
      4'd0:    a = 17'd0;
      4'd1:    a = 17'd256;
      4'd2:    a = 17'd360;
      4'd3:    a = 17'd511;
      4'd4:    a = 17'd724;
      4'd5:    a = 17'd1022;
      4'd6:    a = 17'd1445;
      4'd7:    a = 17'd2045;
      4'd8:    a = 17'd2893;
      4'd9:    a = 17'd4093;
      4'd10:   a = 17'd5787;
      4'd11:   a = 17'd8185;
      4'd12:   a = 17'd11583;
      4'd13:   a = 17'd16384;
      4'd14:   a = 17'd23170;
      4'd15:   a = 17'd32768;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/psg_tone_noise_envelope_unit.sv =====
// Top level of the three-channel PSG: register file, dividers, envelope, mixer.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready. in_tuser carries the operation
//   (select address, write, read, tick); in_tdata carries the address or data.
//   Every accepted word produces exactly one result word on out_tvalid/
//   out_tready: read data (zero unless a read) plus the three gated volume
//   codes and the Q2.15 sum of their table amplitudes, all taken after the
//   word has been applied.
//   Path: a word passes the input register, then the result register.
//   Throughput: one word per clock while the output is not stalled; the
//   whole update of a word is a single registered pass through the
//   dividers, the envelope step and the amplitude table.
//   Stall: while the result register is full and out_tready is low, the
//   input register holds one more word and in_tready drops; nothing is lost.
//   Reset (rst_n low, synchronous) empties both registers, clears the
//   register file except the mixer (0x3F), clears counters and the envelope,
//   and loads the noise LFSR with 1.
module psg_tone_noise_envelope_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [7:0] read_data, [11:8] level_a, [15:12] level_b,
                                  // [19:16] level_c, [36:20] mix_sum, [39:37] zero
);
  import psg_pkg::*;

  // Input register
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [7:0] s1_data_r;
  logic       adv;

  // Generator state
  logic [7:0]  reg_r      [NUM_REGS];
  logic [7:0]  reg_nxt    [NUM_REGS];
  logic [3:0]  sel_addr_r, sel_addr_nxt;
  logic [11:0] tone_cnt_r [NUM_CHAN];
  logic [11:0] tone_cnt_nxt [NUM_CHAN];
  logic [NUM_CHAN-1:0] tone_lvl_r, tone_lvl_nxt;
  logic [4:0]  noise_cnt_r, noise_cnt_nxt;
  logic [16:0] lfsr_r, lfsr_nxt;
  logic        noise_lvl_r, noise_lvl_nxt;
  logic [15:0] env_cnt_r, env_cnt_nxt;
  logic [3:0]  env_vol_r, env_vol_nxt;
  logic        env_holding_r, env_holding_nxt;
  logic        env_attack_r, env_attack_nxt;
  logic        env_alt_r, env_alt_nxt;
  logic        env_hold_r, env_hold_nxt;

  // Result register
  logic        out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;

  logic        is_tick, is_write, is_read;
  logic [7:0]  wr_val;
  logic [11:0] tone_per, tone_inc;
  logic [4:0]  noise_per, noise_inc;
  logic [15:0] env_per, env_inc;
  logic [3:0]  shape;

  psg_chan_t        chan      [NUM_CHAN];
  logic [3:0]       lvl       [NUM_CHAN];
  logic [MIX_W-1:0] amp       [NUM_CHAN];
  logic [MIX_W-1:0] mix_sum;
  logic [7:0]       read_data;

  // Handshake: the input register moves on when the result slot is free
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_tick  = (s1_op_r == OP_TICK);
  assign is_write = (s1_op_r == OP_WRITE);
  assign is_read  = (s1_op_r == OP_READ);

  // Mask the write data by register
  always_comb begin
    case (sel_addr_r) inside
      ADDR_TONE_A_HI, ADDR_TONE_B_HI, ADDR_TONE_C_HI, ADDR_SHAPE:
        wr_val = {4'd0, s1_data_r[3:0]};
      ADDR_NOISE, ADDR_AMP_A, ADDR_AMP_B, ADDR_AMP_C:
        wr_val = {3'd0, s1_data_r[4:0]};
      default:
        wr_val = s1_data_r;
    endcase
  end

  // Address select and register writes
  always_comb begin
    sel_addr_nxt = (s1_op_r == OP_SELECT) ? s1_data_r[3:0] : sel_addr_r;
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_nxt[i] = reg_r[i];
    end
    if (is_write) begin
      reg_nxt[sel_addr_r] = wr_val;
    end
  end

  // Tone dividers: zero period counts as one
  always_comb begin
    tone_per = '0;
    tone_inc = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      tone_per = {reg_r[2*ch+1][3:0], reg_r[2*ch]};
      if (tone_per == '0) begin
        tone_per = 12'd1;
      end
      tone_inc = tone_cnt_r[ch] + 12'd1;
      tone_cnt_nxt[ch] = tone_cnt_r[ch];
      tone_lvl_nxt[ch] = tone_lvl_r[ch];
      if (is_tick) begin
        if (tone_inc >= tone_per) begin
          tone_cnt_nxt[ch] = '0;
          tone_lvl_nxt[ch] = !tone_lvl_r[ch];
        end else begin
          tone_cnt_nxt[ch] = tone_inc;
        end
      end
    end
  end

  // Noise divider and LFSR shift
  always_comb begin
    noise_per = reg_r[ADDR_NOISE][4:0];
    if (noise_per == '0) begin
      noise_per = 5'd1;
    end
    noise_inc     = noise_cnt_r + 5'd1;
    noise_cnt_nxt = noise_cnt_r;
    lfsr_nxt      = lfsr_r;
    noise_lvl_nxt = noise_lvl_r;
    if (is_tick) begin
      if (noise_inc >= noise_per) begin
        noise_cnt_nxt = '0;
        lfsr_nxt      = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[16:1]};
        noise_lvl_nxt = lfsr_r[1];
      end else begin
        noise_cnt_nxt = noise_inc;
      end
    end
  end

  // Envelope: restart on shape write, step on divider wrap
  always_comb begin
    shape   = s1_data_r[3:0];
    env_per = {reg_r[ADDR_ENV_HI], reg_r[ADDR_ENV_LO]};
    if (env_per == '0) begin
      env_per = 16'd1;
    end
    env_inc         = env_cnt_r + 16'd1;
    env_cnt_nxt     = env_cnt_r;
    env_vol_nxt     = env_vol_r;
    env_holding_nxt = env_holding_r;
    env_attack_nxt  = env_attack_r;
    env_alt_nxt     = env_alt_r;
    env_hold_nxt    = env_hold_r;
    if (is_write && sel_addr_r == ADDR_SHAPE) begin
      env_cnt_nxt     = '0;
      env_holding_nxt = 1'b0;
      env_attack_nxt  = shape[2];
      // One-shot shapes hold at zero after a single ramp
      env_alt_nxt     = shape[3] ? shape[1] : shape[2];
      env_hold_nxt    = shape[3] ? shape[0] : 1'b1;
      env_vol_nxt     = shape[2] ? VOL_MIN : VOL_MAX;
    end else if (is_tick && !env_holding_r) begin
      if (env_inc < env_per) begin
        env_cnt_nxt = env_inc;
      end else begin
        env_cnt_nxt = '0;
        if (env_attack_r) begin
          if (env_vol_r != VOL_MAX) begin
            env_vol_nxt = env_vol_r + 4'd1;
          end else if (env_hold_r) begin
            if (env_alt_r) begin
              env_vol_nxt = VOL_MIN;
            end
            env_holding_nxt = 1'b1;
          end else if (env_alt_r) begin
            env_attack_nxt = 1'b0;
          end else begin
            env_vol_nxt = VOL_MIN;
          end
        end else begin
          if (env_vol_r != VOL_MIN) begin
            env_vol_nxt = env_vol_r - 4'd1;
          end else if (env_hold_r) begin
            if (env_alt_r) begin
              env_vol_nxt = VOL_MAX;
            end
            env_holding_nxt = 1'b1;
          end else if (env_alt_r) begin
            env_attack_nxt = 1'b1;
          end else begin
            env_vol_nxt = VOL_MAX;
          end
        end
      end
    end
  end

  // Gate each channel from the updated state
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      chan[ch].tone_off  = reg_nxt[ADDR_MIXER][ch];
      chan[ch].noise_off = reg_nxt[ADDR_MIXER][ch+NUM_CHAN];
      chan[ch].env_mode  = reg_nxt[ADDR_AMP_A + 4'(ch)][4];
      chan[ch].fixed_vol = reg_nxt[ADDR_AMP_A + 4'(ch)][3:0];
      chan[ch].env_vol   = env_vol_nxt;
      chan[ch].tone_lvl  = tone_lvl_nxt[ch];
      chan[ch].noise_lvl = noise_lvl_nxt;
    end
  end

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
    psg_chan_level u_level (
      .chan  (chan[g]),
      .level (lvl[g]),
      .amp   (amp[g])
    );
  end

  // Assemble the result word
  always_comb begin
    mix_sum      = amp[0] + amp[1] + amp[2];
    read_data    = is_read ? reg_r[sel_addr_r] : 8'd0;
    out_data_nxt = {3'd0, mix_sum, lvl[2], lvl[1], lvl[0], read_data};
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Generator state commits when a word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_r[i] <= (4'(i) == ADDR_MIXER) ? MIXER_RESET : 8'd0;
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        tone_cnt_r[ch] <= '0;
      end
      sel_addr_r    <= '0;
      tone_lvl_r    <= '0;
      noise_cnt_r   <= '0;
      lfsr_r        <= 17'd1;
      noise_lvl_r   <= 1'b0;
      env_cnt_r     <= '0;
      env_vol_r     <= '0;
      env_holding_r <= 1'b0;
      env_attack_r  <= 1'b0;
      env_alt_r     <= 1'b0;
      env_hold_r    <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_r[i] <= reg_nxt[i];
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        tone_cnt_r[ch] <= tone_cnt_nxt[ch];
      end
      sel_addr_r    <= sel_addr_nxt;
      tone_lvl_r    <= tone_lvl_nxt;
      noise_cnt_r   <= noise_cnt_nxt;
      lfsr_r        <= lfsr_nxt;
      noise_lvl_r   <= noise_lvl_nxt;
      env_cnt_r     <= env_cnt_nxt;
      env_vol_r     <= env_vol_nxt;
      env_holding_r <= env_holding_nxt;
      env_attack_r  <= env_attack_nxt;
      env_alt_r     <= env_alt_nxt;
      env_hold_r    <= env_hold_nxt;
    end
  end

  // The envelope only ever holds at an end of its range
  a_env_hold_end: assert property (@(posedge clk) disable iff (!rst_n)
    env_holding_r |-> (env_vol_r == VOL_MIN || env_vol_r == VOL_MAX))
    else $error("envelope holding at a middle volume");

  // The noise LFSR never locks up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise LFSR reached zero");

  // Only a read returns nonzero read data
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_read) |=> (out_data_r[7:0] == 8'd0))
    else $error("read data on a non-read word");

  // Silent channels contribute nothing to the mix
  a_mix_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[19:8] == 12'd0) |-> (out_data_r[36:20] == '0))
    else $error("nonzero mix with all channels silent");

endmodule

// ===== src/psg_chan_level.sv =====
// Mixer gating of one channel and lookup of its table amplitude.
module psg_chan_level (
  input  psg_pkg::psg_chan_t        chan,
  output logic [3:0]                level,
  output logic [psg_pkg::MIX_W-1:0] amp
);
  import psg_pkg::*;

  logic [3:0] vol;
  logic       on;

  // Pick envelope or fixed volume, then gate by the enabled sources
  always_comb begin
    vol = chan.env_mode ? chan.env_vol : chan.fixed_vol;
    on  = (!chan.tone_off && chan.tone_lvl) || (!chan.noise_off && chan.noise_lvl);
    level = on ? vol : VOL_MIN;
  end

  assign amp = amp_q15(level);

endmodule

// ===== dv/psg_tone_noise_envelope_unit_tb.sv =====
// Self-checking testbench for the PSG tone/noise/envelope unit, with an in-bench predictor.
`timescale 1ns / 100ps

module psg_tone_noise_envelope_unit_tb;
  import psg_pkg::*;

  // One input word: operation and its data byte
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } psg_word_t;

  // One result word, unpacked from out_tdata
  typedef struct packed {
    logic [7:0]       read_data;
    logic [3:0]       level_a;
    logic [3:0]       level_b;
    logic [3:0]       level_c;
    logic [MIX_W-1:0] mix_sum;
  } psg_result_t;

  localparam int unsigned GAP_PCT = 12;
  localparam int unsigned RANDOM_WORDS = 1100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  psg_word_t   pending_words[$];
  psg_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Shadow of the generator state
  logic [7:0]  shadow_regs [NUM_REGS];
  logic [3:0]  shadow_sel;
  logic [11:0] tone_cnt [NUM_CHAN];
  logic        tone_lvl [NUM_CHAN];
  logic [4:0]  noise_cnt;
  logic [16:0] noise_lfsr;
  logic        noise_lvl;
  logic [15:0] env_cnt;
  logic [3:0]  env_vol;
  logic        env_holding;
  logic        env_attack;
  logic        env_alt;
  logic        env_hold;

  psg_tone_noise_envelope_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Q1.15 amplitude of a volume code
  function automatic logic [MIX_W-1:0] volume_to_q15(input logic [3:0] code);
    logic [MIX_W-1:0] a;
    case (code)
      4'd1:    a = 17'd256;
      4'd2:    a = 17'd360;
      4'd3:    a = 17'd511;
      4'd4:    a = 17'd724;
      4'd5:    a = 17'd1022;
      4'd6:    a = 17'd1445;
      4'd7:    a = 17'd2045;
      4'd8:    a = 17'd2893;
      4'd9:    a = 17'd4093;
      4'd10:   a = 17'd5787;
      4'd11:   a = 17'd8185;
      4'd12:   a = 17'd11583;
      4'd13:   a = 17'd16384;
      4'd14:   a = 17'd23170;
      4'd15:   a = 17'd32768;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = 8'h00;
    shadow_regs[ADDR_MIXER] = MIXER_RESET;
    shadow_sel = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      tone_cnt[ch] = '0;
      tone_lvl[ch] = 1'b0;
    end
    noise_cnt = '0;
    noise_lfsr = 17'd1;
    noise_lvl = 1'b0;
    env_cnt = '0;
    env_vol = VOL_MIN;
    {env_holding, env_attack, env_alt, env_hold} = 4'b0000;
  endtask

  // Apply one word to the shadow state and return the result it produces
  function automatic psg_result_t step_generator(input logic [1:0] op, input logic [7:0] data);
    psg_result_t r;
    logic [7:0]  v;
    logic [11:0] tper;
    logic [4:0]  nper;
    logic [15:0] eper;
    logic        fb;
    logic [7:0]  amp;
    logic [3:0]  vol;
    logic        t_off;
    logic        n_off;
    logic [3:0]  lv [NUM_CHAN];
    r = '0;
    case (op)
      OP_SELECT: shadow_sel = data[3:0];
      OP_WRITE: begin
        v = data;
        case (shadow_sel)
          ADDR_TONE_A_HI, ADDR_TONE_B_HI, ADDR_TONE_C_HI: v = v & 8'h0F;
          ADDR_NOISE, ADDR_AMP_A, ADDR_AMP_B, ADDR_AMP_C: v = v & 8'h1F;
          ADDR_SHAPE: begin
            // restart the envelope; a one-shot shape holds at zero after one ramp
            v = v & 8'h0F;
            env_cnt = '0;
            env_holding = 1'b0;
            env_attack = v[2];
            if (v[3]) begin
              env_alt = v[1];
              env_hold = v[0];
            end else begin
              env_alt = v[2];
              env_hold = 1'b1;
            end
            env_vol = v[2] ? VOL_MIN : VOL_MAX;
          end
          default: ;
        endcase
        shadow_regs[shadow_sel] = v;
      end
      OP_READ: r.read_data = shadow_regs[shadow_sel];
      default: begin
        // advance the tone dividers; a zero period counts as one
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          tper = {shadow_regs[2*ch+1][3:0], shadow_regs[2*ch]};
          if (tper == 0) tper = 12'd1;
          tone_cnt[ch] = tone_cnt[ch] + 12'd1;
          if (tone_cnt[ch] >= tper) begin
            tone_cnt[ch] = '0;
            tone_lvl[ch] = ~tone_lvl[ch];
          end
        end
        // advance the noise divider and shift the LFSR on wrap
        nper = shadow_regs[ADDR_NOISE][4:0];
        if (nper == 0) nper = 5'd1;
        noise_cnt = noise_cnt + 5'd1;
        if (noise_cnt >= nper) begin
          fb = noise_lfsr[0] ^ noise_lfsr[3];
          noise_cnt = '0;
          noise_lfsr = {fb, noise_lfsr[16:1]};
          noise_lvl = noise_lfsr[0];
        end
        // step the envelope unless it is holding
        if (!env_holding) begin
          eper = {shadow_regs[ADDR_ENV_HI], shadow_regs[ADDR_ENV_LO]};
          if (eper == 0) eper = 16'd1;
          env_cnt = env_cnt + 16'd1;
          if (env_cnt >= eper) begin
            env_cnt = '0;
            if (env_attack) begin
              if (env_vol != VOL_MAX) env_vol = env_vol + 4'd1;
              else if (env_hold) begin
                if (env_alt) env_vol = VOL_MIN;
                env_holding = 1'b1;
              end else if (env_alt) env_attack = 1'b0;
              else env_vol = VOL_MIN;
            end else begin
              if (env_vol != VOL_MIN) env_vol = env_vol - 4'd1;
              else if (env_hold) begin
                if (env_alt) env_vol = VOL_MAX;
                env_holding = 1'b1;
              end else if (env_alt) env_attack = 1'b1;
              else env_vol = VOL_MAX;
            end
          end
        end
      end
    endcase
    // gate each channel through the mixer and sum the amplitudes
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      amp = shadow_regs[ADDR_AMP_A + ch];
      vol = amp[4] ? env_vol : amp[3:0];
      t_off = shadow_regs[ADDR_MIXER][ch];
      n_off = shadow_regs[ADDR_MIXER][ch+3];
      if (vol == 0 || (t_off && n_off)) lv[ch] = 4'd0;
      else if ((!t_off && tone_lvl[ch]) || (!n_off && noise_lvl)) lv[ch] = vol;
      else lv[ch] = 4'd0;
      r.mix_sum = r.mix_sum + volume_to_q15(lv[ch]);
    end
    r.level_a = lv[0];
    r.level_b = lv[1];
    r.level_c = lv[2];
    return r;
  endfunction

  // Random gap; none during the burst window
  function automatic bit gap_now();
    if (cycle_count >= 300 && cycle_count < 800) return 1'b0;
    return $urandom_range(0, 99) < GAP_PCT;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_word(input logic [1:0] op, input logic [7:0] data);
    pending_words.push_back('{op: op, data: data});
  endtask

  task automatic add_write(input logic [3:0] addr, input logic [7:0] value);
    add_word(OP_SELECT, {4'h0, addr});
    add_word(OP_WRITE, value);
  endtask

  // Likely value for a register: small periods so dividers wrap often
  function automatic logic [7:0] pick_value(input logic [3:0] addr);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    case (addr)
      ADDR_TONE_A_HI, ADDR_TONE_B_HI, ADDR_TONE_C_HI, ADDR_ENV_HI:
        if ($urandom_range(0, 9) < 8) v = 8'h00;
      ADDR_NOISE, ADDR_ENV_LO:
        if ($urandom_range(0, 9) < 8) v = 8'($urandom_range(0, 3));
      default:
        if (addr < ADDR_NOISE && !addr[0] && $urandom_range(0, 9) < 7)
          v = 8'($urandom_range(0, 6));
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Driver: predict on acceptance, then load the next word
  always @(posedge clk) begin
    logic      next_valid;
    psg_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(step_generator(in_tuser, in_tdata));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_words.size() != 0 && !gap_now()) begin
        w = pending_words.pop_front();
        in_tuser <= w.op;
        in_tdata <= w.data;
        next_valid = 1'b1;
      end
      in_tvalid <= next_valid;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    psg_result_t want;
    psg_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[11:8], out_tdata[15:12], out_tdata[19:16],
               out_tdata[36:20]};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("level_a", want.level_a, got.level_a);
          check_field("level_b", want.level_b, got.level_b);
          check_field("level_c", want.level_c, got.level_c);
          check_field("mix_sum", want.mix_sum, got.mix_sum);
        end
      end
      out_tready <= !gap_now();
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned kind;
    logic [3:0]  addr;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: masks, unused address bits, reset mixer, zero periods, silence
    add_word(OP_SELECT, 8'hF7);
    add_word(OP_READ, 8'hFF);
    add_write(ADDR_TONE_A_HI, 8'hFF);
    add_word(OP_READ, 8'h00);
    add_write(ADDR_TONE_A_HI, 8'h00);
    add_write(ADDR_AMP_A, 8'hFF);
    add_write(ADDR_AMP_B, 8'h0F);
    add_write(ADDR_SHAPE, 8'hFF);
    add_write(ADDR_MIXER, 8'h00);
    repeat (4) add_word(OP_TICK, 8'hA5);
    add_write(ADDR_MIXER, 8'hFF);
    add_word(OP_TICK, 8'h5A);
    add_write(4'hF, 8'hA5);
    add_word(OP_READ, 8'h00);

    // Random: mostly tick runs and well-formed register accesses
    n = 0;
    while (n < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      addr = 4'($urandom_range(0, 15));
      if (kind < 50) begin
        repeat ($urandom_range(1, 8)) begin
          add_word(OP_TICK, 8'($urandom_range(0, 255)));
          n++;
        end
      end else if (kind < 80) begin
        add_write(addr, pick_value(addr));
        n += 2;
      end else if (kind < 90) begin
        add_word(OP_SELECT, 8'($urandom_range(0, 255)));
        add_word(OP_READ, 8'($urandom_range(0, 255)));
        n += 2;
      end else begin
        add_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        n++;
      end
      // hold the sender once until every result is back
      if (n >= RANDOM_WORDS / 2 && n < RANDOM_WORDS / 2 + 9) begin
        wait_drained();
        n += 9;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== psg_tone_noise_envelope_unit.f =====
src/psg_pkg.sv
src/psg_chan_level.sv
src/psg_tone_noise_envelope_unit.sv
dv/psg_tone_noise_envelope_unit_tb.sv
